[sv/mdaa_pkg.sv]
package mdaa_pkg;

   // default sizes of the descriptor tables
   localparam int NUM_ARRAYS_DEF = 16;
   localparam int MAX_DIMS_DEF   = 10;

   // stream widths
   localparam int REQ_TDATA_W = 160;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      ACT_HEADER = 2'd0,
      ACT_BOUNDS = 2'd1,
      ACT_INDEX  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_ADDR
   } state_type;

   // descriptor header entry
   typedef struct packed {
      logic [31:0] base;
      logic [15:0] esize;
      logic [3:0]  ndims;
   } hdr_type;

   // one dimension's bounds
   typedef struct packed {
      logic [31:0] lower;
      logic [31:0] upper;
   } bnd_type;

   // controls from sequencer to arithmetic
   typedef struct packed {
      logic mac;
      logic clear;
   } calc_ctrl_type;

endpackage

[sv/mdaa_ram.sv]
module mdaa_ram #(
   parameter int WIDTH = $bits(mdaa_pkg::hdr_type),
   parameter int DEPTH = mdaa_pkg::NUM_ARRAYS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mdaa_calc.sv]
module mdaa_calc (
   input  logic                    clock,
   input  logic                    reset,
   input  mdaa_pkg::calc_ctrl_type ctrl,
   input  mdaa_pkg::hdr_type       hdr,
   input  mdaa_pkg::bnd_type       bnd,
   input  logic [31:0]             subscript,
   output logic [31:0]             address
);
   import mdaa_pkg::*;

   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic [31:0] extent;
   logic [31:0] delta;

   // horner step, wraps mod 2^32
   assign extent = bnd.upper - bnd.lower + 32'd1;
   assign delta  = subscript - bnd.lower;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.mac) begin
         acc_in = acc_ff * extent + delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // final scale by element size
   assign address = hdr.base + acc_ff * {16'd0, hdr.esize};

endmodule

[sv/multidim_array_address_unit.sv]
// a header or bounds word is written into its table; a subscript word takes a
// descriptor read, then a multiply-add; after the last subscript an address step
// scales by element size and loads the result into the rsp registers once rsp is free
// one word at a time: a subscript word holds off further requests until its
// horner multiply-add and any address step are done; load words go back to back when idle
// reset: synchronous active high; clears sequencer, counter, slot and accumulator
module multidim_array_address_unit #(
   parameter int NUM_ARRAYS = mdaa_pkg::NUM_ARRAYS_DEF,
   parameter int MAX_DIMS   = mdaa_pkg::MAX_DIMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // slot[3:0] dim[7:4] base_address[39:8] element_size[55:40] dim_count[59:56]
   // lower_bound[91:60] upper_bound[123:92] subscript[155:124], zero fill to 160
   input  logic [mdaa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [mdaa_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_slot[3:0] address[35:4], zero fill to 40
   output logic [mdaa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mdaa_pkg::*;

   localparam int HDR_AW = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int BND_DEPTH = NUM_ARRAYS * MAX_DIMS;
   localparam int BND_AW = (BND_DEPTH > 1) ? $clog2(BND_DEPTH) : 1;
   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   // request fields
   logic [1:0]  req_action;
   logic [3:0]  req_slot;
   logic [3:0]  req_dim;
   logic [31:0] req_base;
   logic [15:0] req_esize;
   logic [3:0]  req_count;
   logic [31:0] req_lower;
   logic [31:0] req_upper;
   logic [31:0] req_sub;

   assign req_action = req_tuser[1:0];
   assign req_slot   = req_tdata[3:0];
   assign req_dim    = req_tdata[7:4];
   assign req_base   = req_tdata[39:8];
   assign req_esize  = req_tdata[55:40];
   assign req_count  = req_tdata[59:56];
   assign req_lower  = req_tdata[91:60];
   assign req_upper  = req_tdata[123:92];
   assign req_sub    = req_tdata[155:124];

   // sequencer and sequence state
   state_type      state_ff, state_in;
   logic [DIM_W-1:0] cnt_ff, cnt_in;
   logic [3:0]     active_slot_ff;
   logic [31:0]    sub_ff;
   logic           rsp_valid_ff;
   logic [3:0]     rsp_slot_ff;
   logic [31:0]    rsp_addr_ff;

   logic           accept;
   logic           slot_ok;
   logic           dim_ok;
   logic           seq_start;
   logic           idx_go;
   logic           hdr_wr;
   logic           bnd_wr;
   logic [3:0]     slot_sel;
   logic [3:0]     count_clamped;
   logic           last_dim;
   logic           rsp_free;
   logic           rsp_load;
   hdr_type        hdr_wdata;
   hdr_type        hdr_rdata;
   bnd_type        bnd_wdata;
   bnd_type        bnd_rdata;
   logic [HDR_AW-1:0] hdr_waddr;
   logic [HDR_AW-1:0] hdr_raddr;
   logic [BND_AW-1:0] bnd_waddr;
   logic [BND_AW-1:0] bnd_raddr;
   calc_ctrl_type  calc_ctrl;
   logic [31:0]    calc_addr;

   assign accept    = req_tvalid && req_tready;
   assign slot_ok   = int'(req_slot) < NUM_ARRAYS;
   assign dim_ok    = int'(req_dim) < MAX_DIMS;
   assign seq_start = (cnt_ff == '0);

   // first subscript of a run picks the slot; later ones follow it
   assign slot_sel = seq_start ? req_slot : active_slot_ff;

   // decode the accepted word
   always_comb begin
      idx_go = 1'b0;
      hdr_wr = 1'b0;
      bnd_wr = 1'b0;
      case (req_action)
         ACT_HEADER: hdr_wr = accept && slot_ok;
         ACT_BOUNDS: bnd_wr = accept && slot_ok && dim_ok;
         ACT_INDEX:  idx_go = accept && (!seq_start || slot_ok);
         default: begin
            idx_go = 1'b0;
         end
      endcase
   end

   // dimension count kept within one to the table depth
   always_comb begin
      count_clamped = req_count;
      if (req_count == 4'd0) begin
         count_clamped = 4'd1;
      end else if (int'(req_count) > MAX_DIMS) begin
         count_clamped = 4'(MAX_DIMS);
      end
   end

   assign hdr_wdata = '{base: req_base, esize: req_esize, ndims: count_clamped};
   assign bnd_wdata = '{lower: req_lower, upper: req_upper};
   assign hdr_waddr = HDR_AW'(int'(req_slot));
   assign hdr_raddr = HDR_AW'(int'(slot_sel));
   assign bnd_waddr = BND_AW'(int'(req_slot) * MAX_DIMS + int'(req_dim));
   assign bnd_raddr = BND_AW'(int'(slot_sel) * MAX_DIMS + int'(cnt_ff));

   // descriptor tables; a load is written before any later read samples the table
   mdaa_ram #(
      .WIDTH ($bits(hdr_type)),
      .DEPTH (NUM_ARRAYS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_wr),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_en   (idx_go),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   mdaa_ram #(
      .WIDTH ($bits(bnd_type)),
      .DEPTH (BND_DEPTH)
   ) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_wr),
      .wr_addr (bnd_waddr),
      .wr_data (bnd_wdata),
      .rd_en   (idx_go),
      .rd_addr (bnd_raddr),
      .rd_data (bnd_rdata)
   );

   // run ends once the counter plus one reaches the current dimension count
   assign last_dim = ({1'b0, 4'(cnt_ff)} + 5'd1) >= {1'b0, hdr_rdata.ndims};

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (idx_go) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            state_in = last_dim ? ST_ADDR : ST_IDLE;
         end
         ST_ADDR: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready      = 1'b0;
      calc_ctrl.mac   = 1'b0;
      calc_ctrl.clear = 1'b0;
      rsp_load        = 1'b0;
      cnt_in          = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MAC: begin
            calc_ctrl.mac = 1'b1;
            cnt_in        = last_dim ? '0 : DIM_W'(int'(cnt_ff) + 1);
         end
         ST_ADDR: begin
            // once rsp is free, the address goes out and the accumulator restarts at zero
            rsp_load        = rsp_free;
            calc_ctrl.clear = rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         active_slot_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (idx_go && seq_start) begin
            active_slot_ff <= req_slot;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (idx_go) begin
         sub_ff <= req_sub;
      end
      if (rsp_load) begin
         rsp_slot_ff <= active_slot_ff;
         rsp_addr_ff <= calc_addr;
      end
   end

   mdaa_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (calc_ctrl),
      .hdr       (hdr_rdata),
      .bnd       (bnd_rdata),
      .subscript (sub_ff),
      .address   (calc_addr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_addr_ff, rsp_slot_ff};

`ifndef SYNTHESIS
   a_idx_to_mac: assert property (@(posedge clock) disable iff (reset)
      idx_go |=> state_ff == ST_MAC)
      else $error("subscript word did not start a multiply-add");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && last_dim) |=> (state_ff == ST_ADDR && cnt_ff == '0))
      else $error("last dimension did not close the run");

   a_addr_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR && rsp_free) |=> rsp_valid_ff)
      else $error("address step left no response");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) < MAX_DIMS)
      else $error("dimension counter beyond table depth");

   a_mac_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> ($past(state_ff) == ST_IDLE))
      else $error("multiply-add without a preceding table read");
`endif

endmodule
